// ----- rtl/core/tea_pkg.sv -----
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and helper functions of the TEA block encryptor.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned NUM_CELLS = 2 * ROUNDS;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  localparam int unsigned SHL_AMT = 4;
  localparam int unsigned SHR_AMT = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_0_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_1_IDX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_2_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_3_IDX = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t plain_left;
    word_t plain_right;
  } tea_in_t;

  typedef struct packed {
    word_t cipher_left;
    word_t cipher_right;
  } tea_out_t;

  // Block state carried along the cell chain
  typedef struct packed {
    word_t left;
    word_t right;
  } tea_blk_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } tea_key_t;

  // Running sum seen by round r (counted from zero)
  function automatic word_t tea_round_sum(input int unsigned r);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(r + 1) * (2*WORD_W)'(TEA_DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tea_key_regs.sv -----
// ----------------------------------------------------------------------------
// tea_key_regs
// Holds the four 32-bit key words written over the configuration port.
// ----------------------------------------------------------------------------
module tea_key_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tea_pkg::WORD_W-1:0]     cfg_wdata_i,
  output tea_pkg::tea_key_t              key_o
);
  import tea_pkg::*;

  tea_key_t key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        KEY_WORD_0_IDX: key_d.k0 = cfg_wdata_i;
        KEY_WORD_1_IDX: key_d.k1 = cfg_wdata_i;
        KEY_WORD_2_IDX: key_d.k2 = cfg_wdata_i;
        KEY_WORD_3_IDX: key_d.k3 = cfg_wdata_i;
        default:        key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ----- rtl/core/tea_cell.sv -----
// ----------------------------------------------------------------------------
// tea_cell
// One half round of TEA: mixes one word into the other and registers the
// block together with its valid bit.
// ----------------------------------------------------------------------------
module tea_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       half_i,
  input  logic [tea_pkg::WORD_W-1:0] sum_i,
  input  logic [tea_pkg::WORD_W-1:0] key_a_i,
  input  logic [tea_pkg::WORD_W-1:0] key_b_i,
  input  logic                       valid_i,
  input  tea_pkg::tea_blk_t          blk_i,
  output logic                       valid_o,
  output tea_pkg::tea_blk_t          blk_o
);
  import tea_pkg::*;

  logic     valid_q;
  tea_blk_t blk_q, blk_d;
  word_t    src;
  word_t    mix;

  // First half updates left from right, second half updates right from left
  assign src = half_i ? blk_i.left : blk_i.right;
  assign mix = ((src << SHL_AMT) + key_a_i) ^ (src + sum_i) ^ ((src >> SHR_AMT) + key_b_i);

  always_comb begin
    blk_d = blk_i;
    if (half_i) begin
      blk_d.right = blk_i.right + mix;
    end else begin
      blk_d.left = blk_i.left + mix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

// ----- rtl/core/tea_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// tea_block_encrypt_top
// TEA encryption of 64-bit blocks, 32 rounds, fully pipelined.
// ----------------------------------------------------------------------------
// A request (plain_left, plain_right) enters on in_valid_i/in_ready_o; the
// encrypted block leaves on out_valid_o/out_ready_i. The user must write the
// key words through cfg_we_i/cfg_idx_i/cfg_wdata_i while no request is in
// flight; the block does not enforce this. Indexes 0..3 select key words
// 0..3. The datapath is a chain of 64 cells, one half round each, followed
// by an output register. Throughput is one block per cycle while the
// receiver does not stall; the adder depth of a half round sets the clock
// period. Reset clears the key words to zero and empties all cells.
// When the receiver stalls, the output register holds its result and the
// chain keeps moving into any empty cells ahead; a cell stops only when the
// cell in front of it is full and stopped, so requests keep being accepted
// until the chain is full.
// ----------------------------------------------------------------------------
module tea_block_encrypt_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tea_pkg::tea_in_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tea_pkg::tea_out_t              out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tea_pkg::WORD_W-1:0]     cfg_wdata_i
);
  import tea_pkg::*;

  tea_key_t key;

  logic     cell_valid [NUM_CELLS];
  tea_blk_t cell_blk   [NUM_CELLS];
  logic     cell_adv   [NUM_CELLS];

  logic     out_valid_q;
  tea_blk_t out_blk_q;
  logic     out_en;
  tea_blk_t in_blk;

  tea_key_regs u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  assign out_en     = !out_valid_q || out_ready_i;
  assign in_ready_o = cell_adv[0];
  assign in_blk     = '{left: in_req_i.plain_left, right: in_req_i.plain_right};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    localparam word_t SUM  = tea_round_sum(k / 2);
    localparam logic  HALF = (k % 2) == 1;

    // Advance when this cell is empty or the cell in front is advancing
    if (k == NUM_CELLS - 1) begin : g_last
      assign cell_adv[k] = out_en || !cell_valid[k];
    end else begin : g_mid
      assign cell_adv[k] = cell_adv[k+1] || !cell_valid[k];
    end

    if (k == 0) begin : g_first
      tea_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (cell_adv[k]),
        .half_i  (HALF),
        .sum_i   (SUM),
        .key_a_i (HALF ? key.k2 : key.k0),
        .key_b_i (HALF ? key.k3 : key.k1),
        .valid_i (in_valid_i),
        .blk_i   (in_blk),
        .valid_o (cell_valid[k]),
        .blk_o   (cell_blk[k])
      );
    end else begin : g_next
      tea_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (cell_adv[k]),
        .half_i  (HALF),
        .sum_i   (SUM),
        .key_a_i (HALF ? key.k2 : key.k0),
        .key_b_i (HALF ? key.k3 : key.k1),
        .valid_i (cell_valid[k-1]),
        .blk_i   (cell_blk[k-1]),
        .valid_o (cell_valid[k]),
        .blk_o   (cell_blk[k])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= cell_valid[NUM_CELLS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_blk_q <= cell_blk[NUM_CELLS-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = '{cipher_left: out_blk_q.left, cipher_right: out_blk_q.right};

endmodule

// ----- rtl/core/tea_checker.sv -----
// ----------------------------------------------------------------------------
// tea_checker
// Port-level checks of the TEA block encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module tea_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_ready_o,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  tea_pkg::tea_out_t out_rsp_o
);
  import tea_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result dropped or changed");

  // Take requests whenever the output stage can move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("request refused while output stage free");

  // Drop nothing through reset: no result right after it
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result shown right after reset");

  // Intake is blocked only while the output stage is full and stalled
  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without a stalled output");

endmodule

bind tea_block_encrypt_top tea_checker u_tea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tea_block_encrypt_top.
// Plaintext blocks go in over valid/ready in random bursts. A scoreboard
// class computes the 32-round TEA cipher under the current key and checks
// every block that comes out, in order. The key words are rewritten between
// phases while the pipeline is empty. The receiver stalls on its own pattern
// and holds off once for long enough that the whole chain fills up.
// ----------------------------------------------------------------------------
module testbench;
  import tea_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = NUM_CELLS + 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_BLOCKS   = 150;
  localparam int unsigned FILL_AFTER     = 180;

  class cipher_ledger;
    word_t    key_words[NUM_KEYS];
    tea_out_t expected_ciphers[$];
    int unsigned mismatches;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      mismatches = 0;
    endfunction

    function void load_key(input logic [CFG_IDX_W-1:0] idx, input word_t value);
      key_words[idx] = value;
    endfunction

    // 32 rounds; the sum advances by the delta before each round
    function tea_out_t encipher(input tea_in_t blk);
      word_t    l, r, total;
      tea_out_t res;
      l = blk.plain_left;
      r = blk.plain_right;
      total = '0;
      for (int unsigned rnd = 0; rnd < ROUNDS; rnd++) begin
        total += TEA_DELTA;
        l += ((r << SHL_AMT) + key_words[0]) ^ (r + total) ^ ((r >> SHR_AMT) + key_words[1]);
        r += ((l << SHL_AMT) + key_words[2]) ^ (l + total) ^ ((l >> SHR_AMT) + key_words[3]);
      end
      res.cipher_left  = l;
      res.cipher_right = r;
      return res;
    endfunction

    function void note_block(input tea_in_t blk);
      expected_ciphers.push_back(encipher(blk));
    endfunction

    function void check_cipher(input tea_out_t got);
      tea_out_t want;
      if (expected_ciphers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cipher block %h_%h", got.cipher_left, got.cipher_right);
        return;
      end
      want = expected_ciphers.pop_front();
      if (got.cipher_left !== want.cipher_left || got.cipher_right !== want.cipher_right) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cipher mismatch: expected %h_%h, got %h_%h",
                   want.cipher_left, want.cipher_right, got.cipher_left, got.cipher_right);
      end
    endfunction

    function int unsigned pending();
      return expected_ciphers.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  tea_in_t              in_req_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  tea_out_t             out_rsp_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  word_t                cfg_wdata_i;

  cipher_ledger ledger;
  int unsigned  results_seen;
  int unsigned  quiet_cycles;
  bit           long_hold_done;

  tea_block_encrypt_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Outputs come from registers, so the values read here are the ones at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ledger.check_cipher(out_rsp_o);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: segments of random stall density, plus long hold-offs
  initial begin : receiver
    int unsigned density;
    int unsigned span;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      density = $urandom_range(0, 15);
      if (density == 0 || (!long_hold_done && results_seen > FILL_AFTER)) begin
        // Only the hold in the middle of a phase is sure to fill the chain
        if (results_seen > FILL_AFTER) long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat ($urandom_range(150, 260)) @(posedge clk_i);
      end else begin
        span = $urandom_range(10, 80);
        repeat (span) begin
          if (!long_hold_done && results_seen > FILL_AFTER) break;
          out_ready_i <= (density >= 12) || ($urandom_range(0, 15) < density);
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_block(input tea_in_t blk);
    in_valid_i <= 1'b1;
    in_req_i   <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_block(blk);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    ledger.load_key(idx, value);
  endtask

  task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
    write_key_reg(KEY_WORD_0_IDX, k0);
    write_key_reg(KEY_WORD_1_IDX, k1);
    write_key_reg(KEY_WORD_2_IDX, k2);
    write_key_reg(KEY_WORD_3_IDX, k3);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let every request come out, then give the chain time to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic word_t random_word();
    int unsigned pick;
    int unsigned bit_pos;
    pick = $urandom_range(0, 31);
    bit_pos = $urandom_range(0, WORD_W - 1);
    case (pick)
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << bit_pos;
      3:       return ~(word_t'(1) << bit_pos);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    tea_in_t     blk;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < count) begin
        blk.plain_left  = random_word();
        blk.plain_right = random_word();
        send_block(blk);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  task automatic send_directed();
    tea_in_t corner[11];
    corner[0]  = '{32'h0000_0000, 32'h0000_0000};
    corner[1]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};
    corner[2]  = '{32'h0000_0000, 32'hFFFF_FFFF};
    corner[3]  = '{32'hFFFF_FFFF, 32'h0000_0000};
    corner[4]  = '{32'h8000_0000, 32'h8000_0000};
    corner[5]  = '{32'h0000_0001, 32'h0000_0001};
    corner[6]  = '{32'h0000_0001, 32'h8000_0000};
    corner[7]  = '{32'hAAAA_AAAA, 32'h5555_5555};
    corner[8]  = '{32'h5555_5555, 32'hAAAA_AAAA};
    corner[9]  = '{32'h0123_4567, 32'h89AB_CDEF};
    corner[10] = '{32'h7FFF_FFFF, 32'hFFFF_FFFE};
    foreach (corner[i]) send_block(corner[i]);
    pause_sender(0);
  endtask

  initial begin : stimulus
    ledger         = new();
    results_seen   = 0;
    quiet_cycles   = 0;
    long_hold_done = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners under the all-zero reset key, then under the all-ones key
    send_directed();
    drain();
    load_key('1, '1, '1, '1);
    send_directed();
    drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    send_random(PHASE_BLOCKS);
    drain();
    load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_random(PHASE_BLOCKS);
    drain();
    load_key($urandom, $urandom, $urandom, $urandom);
    send_random(PHASE_BLOCKS);
    drain();
    load_key(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send_random(PHASE_BLOCKS);
    drain();
    load_key($urandom, $urandom, $urandom, $urandom);
    send_random(PHASE_BLOCKS);
    drain();

    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- tea_block_encrypt_top.f -----
rtl/core/tea_pkg.sv
rtl/core/tea_key_regs.sv
rtl/core/tea_cell.sv
rtl/core/tea_block_encrypt_top.sv
rtl/core/tea_checker.sv
verif/testbench.sv
